/* rtl/i2cbm_pkg.sv */
`default_nettype none

package i2cbm_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic REG_US_TICKS    = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [7:0] US_TICKS_RST    = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_fail;
  } out_word_t;

endpackage

`default_nettype wire

/* rtl/i2cbm_in_if.sv */
`default_nettype none

interface i2cbm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] write_data;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd, write_data, send_ack, sda_in, input ready);
  modport sink (input valid, cmd, write_data, send_ack, sda_in, output ready);
endinterface

`default_nettype wire

/* rtl/i2cbm_out_if.sv */
`default_nettype none

interface i2cbm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_fail;

  modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
                  ack_fail, input ready);
  modport sink (input valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
                ack_fail, output ready);
endinterface

`default_nettype wire

/* rtl/i2cbm_seq.sv */
`default_nettype none

module i2cbm_seq
  import i2cbm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire in_word_t  in_word,
  input  wire logic [7:0] us_ticks,
  input  wire logic [7:0] ack_timeout,
  output out_word_t      res_nxt
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C,
    PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
    PH_WR_A, PH_WR_SET, PH_WR_HI, PH_WR_LO,
    PH_RD_LO, PH_RD_HI, PH_AK_A, PH_AK_B, PH_AK_C,
    PH_WA_A, PH_WA_B, PH_WA_POLL
  } phase_t;

  typedef enum logic [2:0] {
    LV_LOW, LV_HIGH, LV_KEEP, LV_DATA, LV_ACK
  } lvl_t;

  typedef struct packed {
    lvl_t       scl;
    lvl_t       sda;
    logic       drv;
    logic [2:0] us;
  } seg_t;

  function automatic seg_t seg_of(phase_t ph);
    seg_t s;
    case (ph)
      PH_ST_A:    s = '{LV_HIGH, LV_HIGH, 1'b1, 3'd5};
      PH_ST_B:    s = '{LV_HIGH, LV_LOW,  1'b1, 3'd6};
      PH_ST_C:    s = '{LV_LOW,  LV_LOW,  1'b1, 3'd0};
      PH_SP_A:    s = '{LV_LOW,  LV_KEEP, 1'b1, 3'd0};
      PH_SP_B:    s = '{LV_LOW,  LV_LOW,  1'b1, 3'd0};
      PH_SP_C:    s = '{LV_HIGH, LV_LOW,  1'b1, 3'd6};
      PH_SP_D:    s = '{LV_HIGH, LV_HIGH, 1'b1, 3'd6};
      PH_WR_A:    s = '{LV_LOW,  LV_KEEP, 1'b1, 3'd0};
      PH_WR_SET:  s = '{LV_LOW,  LV_DATA, 1'b1, 3'd0};
      PH_WR_HI:   s = '{LV_HIGH, LV_DATA, 1'b1, 3'd2};
      PH_WR_LO:   s = '{LV_LOW,  LV_DATA, 1'b1, 3'd2};
      PH_RD_LO:   s = '{LV_LOW,  LV_HIGH, 1'b0, 3'd2};
      PH_RD_HI:   s = '{LV_HIGH, LV_HIGH, 1'b0, 3'd1};
      PH_AK_A:    s = '{LV_LOW,  LV_ACK,  1'b1, 3'd2};
      PH_AK_B:    s = '{LV_HIGH, LV_ACK,  1'b1, 3'd5};
      PH_AK_C:    s = '{LV_LOW,  LV_ACK,  1'b1, 3'd0};
      PH_WA_A:    s = '{LV_KEEP, LV_HIGH, 1'b0, 3'd1};
      PH_WA_B:    s = '{LV_HIGH, LV_HIGH, 1'b0, 3'd1};
      PH_WA_POLL: s = '{LV_KEEP, LV_KEEP, 1'b0, 3'd0};
      default:    s = '{LV_KEEP, LV_KEEP, 1'b1, 3'd0};
    endcase
    return s;
  endfunction

  function automatic logic lvl_of(lvl_t code, logic cur, logic dbit, logic ack);
    logic v;
    case (code)
      LV_LOW:  v = 1'b0;
      LV_HIGH: v = 1'b1;
      LV_DATA: v = dbit;
      LV_ACK:  v = ~ack;
      default: v = cur;
    endcase
    return v;
  endfunction

  phase_t      phase_r, phase_nxt, ent_ph;
  logic [2:0]  active_cmd_r, active_cmd_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [10:0] delay_r, delay_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        ack_choice_r, ack_choice_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drv_r, drv_nxt;
  logic [7:0]  read_data_r, read_data_nxt;
  logic        ack_fail_r, ack_fail_nxt;
  logic        done_r, done_nxt;
  logic        do_enter;
  seg_t        seg;
  logic [10:0] ticks;

  always_comb begin
    phase_nxt      = phase_r;
    active_cmd_nxt = active_cmd_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    delay_nxt      = delay_r;
    poll_nxt       = poll_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    drv_nxt        = drv_r;
    read_data_nxt  = read_data_r;
    ack_fail_nxt   = ack_fail_r;
    done_nxt       = 1'b0;
    do_enter       = 1'b0;
    ent_ph         = PH_IDLE;

    if (phase_r == PH_IDLE) begin
      if (in_word.cmd >= CMD_START && in_word.cmd <= CMD_WAIT_ACK) begin
        active_cmd_nxt = in_word.cmd;
        bit_count_nxt  = '0;
        poll_nxt       = '0;
        do_enter       = 1'b1;
        case (in_word.cmd)
          CMD_START: ent_ph = PH_ST_A;
          CMD_STOP:  ent_ph = PH_SP_A;
          CMD_WRITE: begin
            shift_nxt = in_word.write_data;
            ent_ph    = PH_WR_A;
          end
          CMD_READ: begin
            ack_choice_nxt = in_word.send_ack;
            shift_nxt      = '0;
            ent_ph         = PH_RD_LO;
          end
          default:   ent_ph = PH_WA_A;
        endcase
      end
    end else if (phase_r == PH_WA_POLL) begin
      if (!in_word.sda_in) begin
        scl_nxt      = 1'b0;
        ack_fail_nxt = 1'b0;
        phase_nxt    = PH_IDLE;
        done_nxt     = 1'b1;
      end else if (poll_r == ack_timeout) begin
        do_enter = 1'b1;
        ent_ph   = PH_SP_A;
      end else begin
        poll_nxt = poll_r + 8'd1;
      end
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - 11'd1;
    end else begin
      case (phase_r)
        PH_ST_A:  begin do_enter = 1'b1; ent_ph = PH_ST_B; end
        PH_ST_B:  begin do_enter = 1'b1; ent_ph = PH_ST_C; end
        PH_SP_A:  begin do_enter = 1'b1; ent_ph = PH_SP_B; end
        PH_SP_B:  begin do_enter = 1'b1; ent_ph = PH_SP_C; end
        PH_SP_C:  begin do_enter = 1'b1; ent_ph = PH_SP_D; end
        PH_SP_D: begin
          if (active_cmd_r == CMD_WAIT_ACK) ack_fail_nxt = 1'b1;
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
        PH_WR_A:   begin do_enter = 1'b1; ent_ph = PH_WR_SET; end
        PH_WR_SET: begin do_enter = 1'b1; ent_ph = PH_WR_HI; end
        PH_WR_HI:  begin do_enter = 1'b1; ent_ph = PH_WR_LO; end
        PH_WR_LO: begin
          shift_nxt     = {shift_r[6:0], 1'b0};
          bit_count_nxt = bit_count_r + 4'd1;
          if (bit_count_nxt >= 4'd8) begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            do_enter = 1'b1;
            ent_ph   = PH_WR_SET;
          end
        end
        PH_RD_LO: begin
          shift_nxt = {shift_r[6:0], in_word.sda_in};
          do_enter  = 1'b1;
          ent_ph    = PH_RD_HI;
        end
        PH_RD_HI: begin
          bit_count_nxt = bit_count_r + 4'd1;
          do_enter      = 1'b1;
          ent_ph        = (bit_count_nxt >= 4'd8) ? PH_AK_A : PH_RD_LO;
        end
        PH_AK_A: begin do_enter = 1'b1; ent_ph = PH_AK_B; end
        PH_AK_B: begin do_enter = 1'b1; ent_ph = PH_AK_C; end
        PH_WA_A: begin do_enter = 1'b1; ent_ph = PH_WA_B; end
        PH_WA_B: begin do_enter = 1'b1; ent_ph = PH_WA_POLL; end
        PH_AK_C: begin
          read_data_nxt = shift_r;
          phase_nxt     = PH_IDLE;
          done_nxt      = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      endcase
    end

    seg   = seg_of(ent_ph);
    ticks = 11'(seg.us) * 11'(us_ticks);
    if (do_enter) begin
      phase_nxt = ent_ph;
      scl_nxt   = lvl_of(seg.scl, scl_r, shift_nxt[7], ack_choice_nxt);
      sda_nxt   = lvl_of(seg.sda, sda_r, shift_nxt[7], ack_choice_nxt);
      drv_nxt   = seg.drv;
      delay_nxt = (ticks == '0) ? '0 : ticks - 11'd1;
    end
  end

  always_comb begin
    res_nxt.scl       = scl_nxt;
    res_nxt.sda_out   = sda_nxt;
    res_nxt.sda_drive = drv_nxt;
    res_nxt.busy_res  = (phase_nxt != PH_IDLE);
    res_nxt.done_res  = done_nxt;
    res_nxt.read_data = read_data_nxt;
    res_nxt.ack_fail  = ack_fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      active_cmd_r <= CMD_NONE;
      bit_count_r  <= '0;
      shift_r      <= '0;
      delay_r      <= '0;
      poll_r       <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      drv_r        <= 1'b1;
      read_data_r  <= '0;
      ack_fail_r   <= 1'b0;
      done_r       <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      active_cmd_r <= active_cmd_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      delay_r      <= delay_nxt;
      poll_r       <= poll_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      drv_r        <= drv_nxt;
      read_data_r  <= read_data_nxt;
      ack_fail_r   <= ack_fail_nxt;
      done_r       <= done_nxt;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> phase_r == PH_IDLE)
    else $error("done flagged outside idle");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= 4'd8)
    else $error("bit count overran the byte");

  a_delay_max: assert property (@(posedge clk) disable iff (!rst_n)
    delay_r <= 11'd1529)
    else $error("delay beyond longest segment");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(delay_r) && $stable(shift_r))
    else $error("sequencer moved without a word");

  a_poll_drive: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WA_POLL |-> !drv_r && scl_r)
    else $error("sda driven or scl low while polling");

endmodule

`default_nettype wire

/* rtl/i2c_bit_master.sv */
// the result word for an input word is registered in the output stage, or in the skid entry while the sink stalls
// throughput: one input word per cycle while the input is ready, one result word per input word
// a two-entry output stage holds results while the sink stalls; input stalls only when both are full
// reset: synchronous, active low; sequencer idle with scl and sda driven high,
// us_ticks 1, ack_timeout 250, read data and ack failure cleared
`default_nettype none

module i2c_bit_master
  import i2cbm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  i2cbm_in_if.sink                 in_if,
  i2cbm_out_if.source              out_if,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [CFG_DW-1:0]   pwdata,
  output logic      [CFG_DW-1:0]   prdata,
  output logic                     pready
);

  logic [7:0] us_ticks_r;
  logic [7:0] ack_timeout_r;
  logic       cfg_wr;
  logic       in_ready;
  logic       accept;
  in_word_t   in_word;
  out_word_t  res_nxt;
  logic       out_v_r;
  logic       skid_v_r;
  out_word_t  out_d_r;
  out_word_t  skid_d_r;
  logic       out_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ACK_TIMEOUT) ? {{(CFG_DW-8){1'b0}}, ack_timeout_r}
                                                 : {{(CFG_DW-8){1'b0}}, us_ticks_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      us_ticks_r    <= US_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_US_TICKS) us_ticks_r <= pwdata[7:0];
      else ack_timeout_r <= pwdata[7:0];
    end
  end

  assign in_ready     = !skid_v_r;
  assign in_if.ready  = in_ready;
  assign accept       = in_if.valid && in_ready;

  assign in_word.cmd        = in_if.cmd;
  assign in_word.write_data = in_if.write_data;
  assign in_word.send_ack   = in_if.send_ack;
  assign in_word.sda_in     = in_if.sda_in;

  i2cbm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .in_word     (in_word),
    .us_ticks    (us_ticks_r),
    .ack_timeout (ack_timeout_r),
    .res_nxt     (res_nxt)
  );

  assign out_load = !out_v_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r  <= skid_v_r || accept;
      skid_v_r <= 1'b0;
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_v_r) out_d_r <= skid_d_r;
      else if (accept) out_d_r <= res_nxt;
    end else if (accept) begin
      skid_d_r <= res_nxt;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.scl       = out_d_r.scl;
  assign out_if.sda_out   = out_d_r.sda_out;
  assign out_if.sda_drive = out_d_r.sda_drive;
  assign out_if.busy_res  = out_d_r.busy_res;
  assign out_if.done_res  = out_d_r.done_res;
  assign out_if.read_data = out_d_r.read_data;
  assign out_if.ack_fail  = out_d_r.ack_fail;

endmodule

`default_nettype wire
